// ===== src/vrbs_pkg.sv =====
// ----------------------------------------------------------------------------
// vrbs_pkg
// Shared types and constants for the variable-length record byte stack:
// field widths, request and result codes, controller/datapath structs.
// ----------------------------------------------------------------------------
package vrbs_pkg;

  // default geometry
  localparam int STACK_BYTES  = 1024;
  localparam int MAX_RECORD   = 64;
  localparam int HEADER_BYTES = 4;

  // fixed field widths
  localparam int REQ_W  = 2;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;
  localparam int STS_W  = 2;
  localparam int FREE_W = 11;

  // request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  // result status codes
  typedef enum logic [STS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } res_status_t;

  // controller to datapath commands
  typedef struct packed {
    logic        accept_push;  // push beat taken this cycle
    logic        drop_run;     // discard any open push run
    logic        do_clear;     // empty the stack
    logic        read_hdr;     // read header byte at top
    logic        take_hdr;     // header data back, size the transfer
    logic        read_next;    // read next record byte
    logic        load_byte;    // load record byte into result register
    logic        write_hdr;    // write header of committed record
    logic        load_status;  // load a status-only result
    res_status_t status;       // status for load_status
    logic        with_stored;  // status result carries stored length
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    req_t req;           // request code of the waiting input beat
    logic push_final;    // a push beat now would end its run
    logic push_refused;  // the run of that beat is refused
    logic empty;         // no record on the stack
    logic count_zero;    // transfer byte count is zero
    logic rem_last;      // one record byte left to load
    logic out_valid;     // result register holds a result
    logic out_taken;     // result beat completes this cycle
  } dp_stat_t;

endpackage

// ===== src/vrbs_if.sv =====
// ----------------------------------------------------------------------------
// vrbs request and result channels
// Valid/ready channels carrying one request item and one result item.
// ----------------------------------------------------------------------------
interface vrbs_req_if;
  logic                             valid;
  logic                             ready;
  logic [vrbs_pkg::REQ_W-1:0]       req_type;
  logic [vrbs_pkg::BYTE_W-1:0]      data_byte;
  logic [vrbs_pkg::LEN_W-1:0]       length;

  modport source (output valid, req_type, data_byte, length, input ready);
  modport sink   (input valid, req_type, data_byte, length, output ready);
endinterface

interface vrbs_res_if;
  logic                             valid;
  logic                             ready;
  logic [vrbs_pkg::BYTE_W-1:0]      out_byte;
  logic                             byte_valid;
  logic                             last;
  logic [vrbs_pkg::STS_W-1:0]       status;
  logic [vrbs_pkg::LEN_W-1:0]       stored_len;
  logic                             empty_res;
  logic [vrbs_pkg::FREE_W-1:0]      free_bytes;

  modport source (output valid, out_byte, byte_valid, last, status, stored_len,
                  empty_res, free_bytes, input ready);
  modport sink   (input valid, out_byte, byte_valid, last, status, stored_len,
                  empty_res, free_bytes, output ready);
endinterface

// ===== src/vrbs_dpath.sv =====
// ----------------------------------------------------------------------------
// vrbs_dpath
// Byte store, top pointer, push run tracking, pop/peek transfer counters and
// the result register of the record stack.
// ----------------------------------------------------------------------------
module vrbs_dpath #(
  parameter int STACK_BYTES  = vrbs_pkg::STACK_BYTES,
  parameter int MAX_RECORD   = vrbs_pkg::MAX_RECORD,
  parameter int HEADER_BYTES = vrbs_pkg::HEADER_BYTES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vrbs_pkg::cmd_t                cmd,
  output vrbs_pkg::dp_stat_t            st,
  input  logic [vrbs_pkg::REQ_W-1:0]    req_type,
  input  logic [vrbs_pkg::BYTE_W-1:0]   data_byte,
  input  logic [vrbs_pkg::LEN_W-1:0]    length,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [vrbs_pkg::BYTE_W-1:0]   out_byte,
  output logic                          byte_valid,
  output logic                          last,
  output logic [vrbs_pkg::STS_W-1:0]    status,
  output logic [vrbs_pkg::LEN_W-1:0]    stored_len,
  output logic                          empty_res,
  output logic [vrbs_pkg::FREE_W-1:0]   free_bytes
);

  localparam int AW = $clog2(STACK_BYTES);
  localparam int PW = $clog2(STACK_BYTES + 1);
  localparam int CW = ((PW > 8) ? PW : 8) + 1;
  localparam int LW = vrbs_pkg::LEN_W;
  localparam int BW = vrbs_pkg::BYTE_W;

  // byte store
  logic [BW-1:0] mem [STACK_BYTES];
  logic [BW-1:0] rd_data;

  // stack and run state
  logic [PW-1:0] top, top_next;
  logic          run_active, run_refused;
  logic [LW-1:0] run_length, run_count;

  // transfer state
  logic [LW-1:0] req_len, stored, rem;
  logic          is_pop;
  logic [PW-1:0] ptr;

  // push run decode
  logic [LW-1:0] len_c, eff_len, eff_cnt, cnt_inc, items;
  logic          eff_ref, room_short, push_final, wr_data_en;
  logic [PW-1:0] push_addr, commit_top;

  // header decode
  logic [LW-1:0] hdr_clamp, hdr_len, cnt_n;
  logic [CW-1:0] room, limit, pop_sum;
  logic [PW-1:0] pop_top;

  // memory port selects
  logic          wr_en, rd_en;
  logic [PW-1:0] wr_addr, rd_addr;
  logic [BW-1:0] wr_data;

  // push run bookkeeping
  always_comb begin
    len_c      = (length > LW'(MAX_RECORD)) ? LW'(MAX_RECORD) : length;
    room_short = CW'(top) < (CW'(len_c) + CW'(HEADER_BYTES));
    eff_len    = run_active ? run_length  : len_c;
    eff_cnt    = run_active ? run_count   : '0;
    eff_ref    = run_active ? run_refused : room_short;
    cnt_inc    = eff_cnt + LW'(1);
    items      = (eff_len == '0) ? LW'(1) : eff_len;
    push_final = (cnt_inc == items);
    wr_data_en = cmd.accept_push && !eff_ref && (eff_cnt < eff_len);
    push_addr  = top - PW'(eff_len) + PW'(eff_cnt);
    commit_top = top - PW'(eff_len) - PW'(HEADER_BYTES);
  end

  // header length clamped to the record room and transfer size
  always_comb begin
    hdr_clamp = (rd_data > BW'(MAX_RECORD)) ? LW'(MAX_RECORD) : rd_data[LW-1:0];
    room      = CW'(STACK_BYTES) - CW'(top);
    limit     = (room < CW'(HEADER_BYTES)) ? '0 : room - CW'(HEADER_BYTES);
    hdr_len   = (CW'(hdr_clamp) > limit) ? LW'(limit) : hdr_clamp;
    cnt_n     = (req_len < hdr_len) ? req_len : hdr_len;
    pop_sum   = CW'(top) + CW'(HEADER_BYTES) + CW'(hdr_len);
    pop_top   = (pop_sum > CW'(STACK_BYTES)) ? PW'(STACK_BYTES) : PW'(pop_sum);
  end

  // next top pointer
  always_comb begin
    top_next = top;
    if (cmd.do_clear) begin
      top_next = PW'(STACK_BYTES);
    end else if (cmd.accept_push && push_final && !eff_ref) begin
      top_next = commit_top;
    end else if (cmd.take_hdr && is_pop) begin
      top_next = pop_top;
    end
  end

  // memory port muxing
  always_comb begin
    wr_en   = wr_data_en || cmd.write_hdr;
    wr_addr = cmd.write_hdr ? top : push_addr;
    wr_data = cmd.write_hdr ? BW'(run_length) : data_byte;
    rd_en   = cmd.read_hdr || cmd.take_hdr || cmd.read_next;
    if (cmd.read_hdr) begin
      rd_addr = top;
    end else if (cmd.take_hdr) begin
      rd_addr = top + PW'(HEADER_BYTES);
    end else begin
      rd_addr = ptr;
    end
  end

  // byte store, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr[AW-1:0]];
    end
  end

  // top pointer and push run registers
  always_ff @(posedge clk) begin
    if (rst) begin
      top         <= PW'(STACK_BYTES);
      run_active  <= 1'b0;
      run_refused <= 1'b0;
      run_length  <= '0;
      run_count   <= '0;
    end else begin
      top <= top_next;
      if (cmd.accept_push) begin
        run_length <= eff_len;
        if (push_final) begin
          run_active  <= 1'b0;
          run_refused <= 1'b0;
          run_count   <= '0;
        end else begin
          run_active  <= 1'b1;
          run_refused <= eff_ref;
          run_count   <= cnt_inc;
        end
      end else if (cmd.drop_run) begin
        run_active  <= 1'b0;
        run_refused <= 1'b0;
        run_count   <= '0;
      end
    end
  end

  // pop and peek transfer registers
  always_ff @(posedge clk) begin
    if (cmd.read_hdr) begin
      req_len <= length;
      is_pop  <= (vrbs_pkg::req_t'(req_type) == vrbs_pkg::REQ_POP);
    end
    if (cmd.take_hdr) begin
      stored <= hdr_len;
      rem    <= cnt_n;
      ptr    <= top + PW'(HEADER_BYTES) + PW'(1);
    end else begin
      if (cmd.read_next) begin
        ptr <= ptr + PW'(1);
      end
      if (cmd.load_byte) begin
        rem <= rem - LW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_status || cmd.load_byte) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_status) begin
      out_byte   <= '0;
      byte_valid <= 1'b0;
      last       <= 1'b1;
      status     <= cmd.status;
      stored_len <= cmd.with_stored ? hdr_len : '0;
      empty_res  <= (top_next == PW'(STACK_BYTES));
      free_bytes <= vrbs_pkg::FREE_W'(top_next);
    end else if (cmd.load_byte) begin
      out_byte   <= rd_data;
      byte_valid <= 1'b1;
      last       <= (rem == LW'(1));
      status     <= vrbs_pkg::ST_OK;
      stored_len <= stored;
      empty_res  <= (top_next == PW'(STACK_BYTES));
      free_bytes <= vrbs_pkg::FREE_W'(top_next);
    end
  end

  // status to the controller
  always_comb begin
    st.req          = vrbs_pkg::req_t'(req_type);
    st.push_final   = push_final;
    st.push_refused = eff_ref;
    st.empty        = (top == PW'(STACK_BYTES));
    st.count_zero   = (cnt_n == '0);
    st.rem_last     = (rem == LW'(1));
    st.out_valid    = out_valid;
    st.out_taken    = out_valid && out_ready;
  end

endmodule

// ===== src/vrbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// vrbs_ctrl
// Sequencer of the record stack: takes request beats, runs header write after
// a committed push and steps the pop/peek byte transfer.
// ----------------------------------------------------------------------------
module vrbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  vrbs_pkg::dp_stat_t st,
  output vrbs_pkg::cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR_WR,
    S_HDR_RD,
    S_BYTE,
    S_WAIT
  } state_t;

  state_t state, state_next;
  logic   acc;

  // request beats only while idle with an empty result register
  assign in_ready = (state == S_IDLE) && !st.out_valid;
  assign acc      = in_valid && in_ready;

  // command decode
  always_comb begin
    cmd        = '0;
    cmd.status = vrbs_pkg::ST_OK;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (acc) begin
          unique case (st.req)
            vrbs_pkg::REQ_PUSH: begin
              cmd.accept_push = 1'b1;
              if (st.push_final) begin
                cmd.load_status = 1'b1;
                cmd.status      = st.push_refused ? vrbs_pkg::ST_FULL
                                                  : vrbs_pkg::ST_OK;
                state_next      = st.push_refused ? S_IDLE : S_HDR_WR;
              end
            end
            vrbs_pkg::REQ_CLEAR: begin
              cmd.drop_run    = 1'b1;
              cmd.do_clear    = 1'b1;
              cmd.load_status = 1'b1;
            end
            default: begin
              // pop or peek
              cmd.drop_run = 1'b1;
              if (st.empty) begin
                cmd.load_status = 1'b1;
                cmd.status      = vrbs_pkg::ST_EMPTY;
              end else begin
                cmd.read_hdr = 1'b1;
                state_next   = S_HDR_RD;
              end
            end
          endcase
        end
      end
      S_HDR_WR: begin
        cmd.write_hdr = 1'b1;
        state_next    = S_IDLE;
      end
      S_HDR_RD: begin
        cmd.take_hdr = 1'b1;
        if (st.count_zero) begin
          cmd.load_status = 1'b1;
          cmd.with_stored = 1'b1;
          state_next      = S_IDLE;
        end else begin
          state_next = S_BYTE;
        end
      end
      S_BYTE: begin
        cmd.load_byte = 1'b1;
        state_next    = st.rem_last ? S_IDLE : S_WAIT;
      end
      S_WAIT: begin
        if (st.out_taken) begin
          cmd.read_next = 1'b1;
          state_next    = S_BYTE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/variable_record_byte_stack.sv =====
// A push, clear or empty-stack result is registered in the cycle after its beat;
//   pop/peek bytes come after a header read, then a byte read of the record.
// Push bytes are taken one per cycle while idle with no result waiting; pop/peek
//   bytes wait for each result beat to be taken (single registered read port, single
//   result register). A committed push then writes its header byte in S_HDR_WR.
// Reset (sync, active high) empties the stack at once; the byte store is not swept.
// ----------------------------------------------------------------------------
// variable_record_byte_stack
// LIFO of variable-length byte records held in a byte store that grows down
// from the top, with push runs, pop, peek and clear requests.
// ----------------------------------------------------------------------------
module variable_record_byte_stack #(
  parameter int STACK_BYTES  = vrbs_pkg::STACK_BYTES,
  parameter int MAX_RECORD   = vrbs_pkg::MAX_RECORD,
  parameter int HEADER_BYTES = vrbs_pkg::HEADER_BYTES
) (
  input logic        clk,
  input logic        rst,
  vrbs_req_if.sink   req,
  vrbs_res_if.source res
);

  vrbs_pkg::cmd_t     cmd;
  vrbs_pkg::dp_stat_t st;

  // sequencer
  vrbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // store and result datapath
  vrbs_dpath #(
    .STACK_BYTES  (STACK_BYTES),
    .MAX_RECORD   (MAX_RECORD),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .st         (st),
    .req_type   (req.req_type),
    .data_byte  (req.data_byte),
    .length     (req.length),
    .out_ready  (res.ready),
    .out_valid  (res.valid),
    .out_byte   (res.out_byte),
    .byte_valid (res.byte_valid),
    .last       (res.last),
    .status     (res.status),
    .stored_len (res.stored_len),
    .empty_res  (res.empty_res),
    .free_bytes (res.free_bytes)
  );

  // no request beat while a result waits
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |-> !res.valid)
    else $error("request beat taken while a result is pending");

  // an empty stack reports the whole store free
  a_empty_free: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.empty_res) |->
      (res.free_bytes == vrbs_pkg::FREE_W'(STACK_BYTES)))
    else $error("empty result with wrong free byte count");

  // record bytes come only with ok status from a non-empty record
  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.byte_valid) |->
      (res.status == vrbs_pkg::ST_OK) && (res.stored_len != '0))
    else $error("record byte with bad status or zero stored length");

  // a byte transfer keeps the result register busy only through its own beats
  a_load_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.read_next |=> !res.valid)
    else $error("next record byte read while result still pending");

endmodule
